// File: rtl/core/wavetable_voice_with_envelope_defines.svh
// Assertion macros for the wavetable voice.
// Included by files that check their own logic; no other dependencies.
`ifndef WAVETABLE_VOICE_WITH_ENVELOPE_DEFINES_SVH
`define WAVETABLE_VOICE_WITH_ENVELOPE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define WV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define WV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/wvenv_pkg.sv
// Shared constants, codes and helpers for the wavetable voice.
// No dependencies; imported by the voice top level.
package wvenv_pkg;

    // Wave memory geometry.
    localparam int WAVE_TABLES = 5;
    localparam int WAVE_LENGTH = 32;
    localparam int MEM_DEPTH   = WAVE_TABLES * WAVE_LENGTH;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int POS_W       = $clog2(WAVE_LENGTH);

    // Phase accumulator arithmetic.
    localparam int PHASE_W = 28;
    localparam logic [15:0] SAMPLE_RATE_MUL = 16'd41700;
    localparam logic [11:0] FREQ_SPAN       = 12'd2048;
    localparam logic [PHASE_W-1:0] CLOCK_ADD = PHASE_W'(5000000);

    // Item function codes.
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;
    localparam logic [1:0] FUNC_TICK  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_FREQ      = 3'd0;
    localparam logic [2:0] REG_WAVE_SEL  = 3'd1;
    localparam logic [2:0] REG_ENV_INIT  = 3'd2;
    localparam logic [2:0] REG_ENV_STEP  = 3'd3;
    localparam logic [2:0] REG_ENV_UP    = 3'd4;
    localparam logic [2:0] REG_ENV_RPT   = 3'd5;
    localparam logic [2:0] REG_VOL_LEFT  = 3'd6;
    localparam logic [2:0] REG_VOL_RIGHT = 3'd7;

    // Envelope end points.
    localparam logic [3:0] ENV_MAX = 4'hf;
    localparam logic [3:0] ENV_MIN = 4'h0;

    // Wave sample midpoint.
    localparam logic [5:0] WAVE_MID = 6'h20;

    // Fold a table selection into range by repeated subtraction.
    function automatic logic [2:0] table_wrap(input logic [2:0] sel);
        logic [3:0] t;
        t = {1'b0, sel};
        for (int i = 0; i < 8; i++)
        begin
            if (t >= 4'(WAVE_TABLES))
            begin
                t = t - 4'(WAVE_TABLES);
            end
        end
        return t[2:0];
    endfunction

    // Channel level from volume and envelope: ((vol*env)>>3)+1, or 0.
    function automatic logic [4:0] channel_level(input logic [3:0] vol,
                                                 input logic [3:0] env);
        logic [7:0] lv;
        lv = vol * env;
        return (lv == 8'd0) ? 5'd0 : 5'(lv >> 3) + 5'd1;
    endfunction

endpackage

// File: rtl/core/wavetable_voice_with_envelope.sv
// Wavetable sound voice with a 4-bit volume envelope.
// Depends on wvenv_pkg and wavetable_voice_with_envelope_defines.svh.
//
// Usage: an input beat carries func plus the wave write fields. A wave write,
// start or stop is handled in S_IDLE and yields no output beat. A sample
// tick yields one output beat with sample_left and sample_right.
// A tick on a stopped voice goes from S_IDLE straight to S_EMIT, which loads the
// output register; a tick on a running voice passes S_DIV, N steps in S_DRAIN,
// S_READ, S_LEVEL and S_EMIT, N being the number of phase subtractions this
// tick performs. The phase drain runs one compare and subtract per cycle on a
// single shared 28-bit add/subtract unit, which also applies the phase increment;
// N is near 120 at the highest pitch and at most about 2170 after a pitch change.
// in_ready is high only while the sequencer is idle; one item is in work at
// a time. The output register holds a finished beat while out_ready is low,
// and the next input beat is still accepted meanwhile; a second tick waits in
// its last step until the register is free.
// Reset clears the configuration, the voice state and the wave memory valid
// bits (entries never written read as zero); there is no clearing pass.
// Configuration writes take effect in the cycle after cfg_wr_en is high.

`include "wavetable_voice_with_envelope_defines.svh"

module wavetable_voice_with_envelope
    import wvenv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [10:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [2:0]         table_number,
    input  logic [4:0]         entry_position,
    input  logic [5:0]         entry_value,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] sample_left,
    output logic signed [15:0] sample_right
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DRAIN,
        S_READ,
        S_LEVEL,
        S_EMIT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [10:0] freq_reg;
    logic [2:0]  wave_sel_reg;
    logic [3:0]  env_init_reg;
    logic [2:0]  env_step_reg;
    logic        env_up_reg;
    logic        env_rpt_reg;
    logic [3:0]  vol_left_reg;
    logic [3:0]  vol_right_reg;

    // Voice state.
    logic               running_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [POS_W-1:0]   wave_pos_reg;
    logic [3:0]         env_level_reg;
    logic [2:0]         env_timer_reg;

    // Working registers of one tick.
    logic [PHASE_W-1:0] div_reg;
    logic [3:0]         env_used_reg;
    logic signed [6:0]  wave_reg;
    logic [4:0]         lvl_left_reg;
    logic [4:0]         lvl_right_reg;

    // Output register.
    logic               out_valid_reg;
    logic signed [15:0] left_reg;
    logic signed [15:0] right_reg;

    // Wave memory with per-entry valid bits.
    logic [5:0]        wave_mem [MEM_DEPTH];
    logic              mem_valid_reg [MEM_DEPTH];
    logic [5:0]        rdata_reg;
    logic              rvalid_reg;
    logic [MEM_AW-1:0] rd_addr;
    logic [MEM_AW-1:0] wr_addr;
    logic              mem_we;

    logic in_accept;
    logic out_free;
    logic start_accept;
    logic tick_accept;

    assign in_ready     = (state_reg == S_IDLE);
    assign in_accept    = in_valid && in_ready;
    assign out_free     = !out_valid_reg || out_ready;
    assign start_accept = in_accept && (func == FUNC_START);
    assign tick_accept  = in_accept && (func == FUNC_TICK);

    assign out_valid    = out_valid_reg;
    assign sample_left  = left_reg;
    assign sample_right = right_reg;

    // Memory addressing; writes to tables beyond the memory are dropped.
    assign mem_we  = in_accept && (func == FUNC_WRITE)
                     && ({1'b0, table_number} < 4'(WAVE_TABLES));
    assign wr_addr = MEM_AW'({table_number, entry_position});
    assign rd_addr = MEM_AW'({table_wrap(wave_sel_reg), wave_pos_reg});

    // Divider for the current pitch: one 16x12 product.
    logic [11:0]        freq_span;
    logic [PHASE_W-1:0] div_prod;

    assign freq_span = FREQ_SPAN - {1'b0, freq_reg};
    assign div_prod  = PHASE_W'(SAMPLE_RATE_MUL) * PHASE_W'(freq_span);

    // Shared add/subtract unit: drains the phase or adds the increment.
    logic               alu_sub;
    logic [PHASE_W-1:0] alu_b;
    logic [PHASE_W:0]   alu_res;
    logic               phase_above;

    assign alu_sub     = (state_reg == S_DRAIN);
    assign alu_b       = alu_sub ? div_reg : CLOCK_ADD;
    assign alu_res     = alu_sub ? ({1'b0, phase_reg} - {1'b0, alu_b})
                                 : ({1'b0, phase_reg} + {1'b0, alu_b});
    assign phase_above = alu_sub && !alu_res[PHASE_W] && (alu_res != '0);

    // Envelope step for this tick.
    logic [3:0] env_next;
    logic [2:0] timer_next;

    always_comb
    begin
        env_next   = env_level_reg;
        timer_next = env_timer_reg + 3'd1;
        if (env_timer_reg == env_step_reg)
        begin
            timer_next = 3'd0;
            if (env_up_reg)
            begin
                if (env_level_reg == ENV_MAX)
                begin
                    if (env_rpt_reg)
                    begin
                        env_next = ENV_MIN;
                    end
                end
                else
                begin
                    env_next = env_level_reg + 4'd1;
                end
            end
            else
            begin
                if (env_level_reg == ENV_MIN)
                begin
                    if (env_rpt_reg)
                    begin
                        env_next = ENV_MAX;
                    end
                end
                else
                begin
                    env_next = env_level_reg - 4'd1;
                end
            end
        end
    end

    // Final scaling: wave times level, then times 32.
    logic signed [12:0] prod_left;
    logic signed [12:0] prod_right;
    logic signed [6:0]  wave_now;

    assign wave_now   = rvalid_reg ? ($signed({1'b0, rdata_reg}) - $signed({1'b0, WAVE_MID}))
                                   : -$signed({1'b0, WAVE_MID});
    assign prod_left  = wave_reg * $signed({1'b0, lvl_left_reg});
    assign prod_right = wave_reg * $signed({1'b0, lvl_right_reg});

    // Wave memory storage and registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wave_mem[wr_addr] <= entry_value;
        end
        rdata_reg  <= wave_mem[rd_addr];
        rvalid_reg <= mem_valid_reg[rd_addr];
    end

    // Valid bits: an entry reads as zero until it is written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MEM_DEPTH; i++)
            begin
                mem_valid_reg[i] <= 1'b0;
            end
        end
        else if (mem_we)
        begin
            mem_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg      <= '0;
            wave_sel_reg  <= '0;
            env_init_reg  <= '0;
            env_step_reg  <= '0;
            env_up_reg    <= 1'b0;
            env_rpt_reg   <= 1'b0;
            vol_left_reg  <= '0;
            vol_right_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FREQ:      freq_reg      <= cfg_data;
                REG_WAVE_SEL:  wave_sel_reg  <= cfg_data[2:0];
                REG_ENV_INIT:  env_init_reg  <= cfg_data[3:0];
                REG_ENV_STEP:  env_step_reg  <= cfg_data[2:0];
                REG_ENV_UP:    env_up_reg    <= cfg_data[0];
                REG_ENV_RPT:   env_rpt_reg   <= cfg_data[0];
                REG_VOL_LEFT:  vol_left_reg  <= cfg_data[3:0];
                REG_VOL_RIGHT: vol_right_reg <= cfg_data[3:0];
                default:       ;
            endcase
        end
    end

    // Tick working registers; payload only, no reset needed.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV)
        begin
            div_reg <= div_prod;
        end
        if (state_reg == S_READ)
        begin
            env_used_reg <= env_level_reg;
        end
        if (tick_accept && !running_reg)
        begin
            wave_reg      <= '0;
            lvl_left_reg  <= '0;
            lvl_right_reg <= '0;
        end
        else if (state_reg == S_LEVEL)
        begin
            wave_reg      <= wave_now;
            lvl_left_reg  <= channel_level(vol_left_reg, env_used_reg);
            lvl_right_reg <= channel_level(vol_right_reg, env_used_reg);
        end
        if ((state_reg == S_EMIT) && out_free)
        begin
            left_reg  <= 16'({prod_left, 5'b0});
            right_reg <= 16'({prod_right, 5'b0});
        end
    end

    // Sequencer, voice state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            running_reg   <= 1'b0;
            phase_reg     <= '0;
            wave_pos_reg  <= '0;
            env_level_reg <= '0;
            env_timer_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new beat replaces the old one; otherwise a taken beat clears.
            if ((state_reg == S_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        unique case (func)
                            FUNC_WRITE: ;
                            FUNC_START:
                            begin
                                if (!running_reg)
                                begin
                                    env_level_reg <= env_init_reg;
                                end
                                running_reg   <= 1'b1;
                                phase_reg     <= '0;
                                wave_pos_reg  <= '0;
                                env_timer_reg <= '0;
                            end
                            FUNC_STOP:
                            begin
                                running_reg <= 1'b0;
                            end
                            FUNC_TICK:
                            begin
                                state_reg <= running_reg ? S_DIV : S_EMIT;
                            end
                            default: ;
                        endcase
                    end
                end

                S_DIV:
                begin
                    state_reg <= S_DRAIN;
                end

                // One subtraction per cycle while the phase exceeds the divider.
                S_DRAIN:
                begin
                    if (phase_above)
                    begin
                        phase_reg    <= alu_res[PHASE_W-1:0];
                        wave_pos_reg <= wave_pos_reg + POS_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end

                // Memory read is issued; phase increment and envelope step.
                S_READ:
                begin
                    phase_reg     <= alu_res[PHASE_W-1:0];
                    env_level_reg <= env_next;
                    env_timer_reg <= timer_next;
                    state_reg     <= S_LEVEL;
                end

                S_LEVEL:
                begin
                    state_reg <= S_EMIT;
                end

                // Leave once the output register has taken the beat.
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Checks on the sequencer and the phase loop.
    `WV_ASSERT_NOW(a_drain_done, state_reg == S_READ, phase_reg <= div_reg, "drain overrun")
    `WV_ASSERT_NEXT(a_pos_hold, (state_reg != S_DRAIN) && !start_accept, $stable(wave_pos_reg), "position moved")
    `WV_ASSERT_NEXT(a_stopped_tick, tick_accept && !running_reg, state_reg == S_EMIT, "stopped tick stuck")

endmodule
